// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Wrappers for concurrent assertions, used by mcws_dp.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is disabled while reset is asserted.
`define MCWS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Clocked assertion that is also checked during reset.
`define MCWS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define MCWS_ASSERT(lbl, clk, rst_n, prop)
`define MCWS_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: rtl/core/mcws_pkg.sv
// ----------------------------------------------------------------------------
// mcws_pkg
// Types and constants shared by the watchdog supervisor modules.
// ----------------------------------------------------------------------------
package mcws_pkg;

    // Default number of client slots.
    localparam int NUM_FEEDERS_DEF = 8;

    // Field widths.
    localparam int SLOT_W    = 3;
    localparam int TMO_W     = 20;
    localparam int CD_W      = 21;
    localparam int REV_W     = 8;
    localparam int TICK_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Configuration reset values.
    localparam logic [REV_W-1:0]  HW_REV_RST        = 8'd2;
    localparam logic              HW_WDOG_RST       = 1'b1;
    localparam logic [TICK_W-1:0] TICK_MS_RST       = 10'd10;
    // Board revision on which signal commands are ignored.
    localparam logic [REV_W-1:0]  HW_REV_NO_SIGNAL  = 8'd1;
    // Lowest countdown value, the 21-bit signed minimum.
    localparam logic [CD_W-1:0]   CD_MIN            = {1'b1, {(CD_W-1){1'b0}}};

    // Command codes.
    typedef enum logic [1:0] {
        OP_PROMISE = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_SIGNAL  = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HW_REV  = 2'd0,
        CFG_HW_WDOG = 2'd1,
        CFG_TICK_MS = 2'd2
    } t_cfg_idx;

    // Input beat.
    typedef struct packed {
        t_op               cmd;
        logic [SLOT_W-1:0] feeder_slot;
        logic [TMO_W-1:0]  timeout_ms;
    } t_in_item;

    // Result beat.
    typedef struct packed {
        logic              keepalive;
        logic              tripped;
        logic              fail_valid;
        logic [SLOT_W-1:0] failed_slot;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SIG_WR,
        ST_WALK,
        ST_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic promise_wr;
        logic remove_wr;
        logic sig_rd;
        logic sig_wr;
        logic walk_start;
        logic walk_step;
        logic resp_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic running;
        logic walk_done;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/multi_client_watchdog_supervisor_top.sv
// Sequence: promise and remove pass decode, then the response state; a signal adds a
// write state after decode, and a tick while running adds the slot walk; the response
// waits until the result register is free. Only one item is in flight at a time, and the
// walk visits one slot a cycle through the single write port of the countdown memory.
// Reset: synchronous; slot valid bits clear at once, no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_client_watchdog_supervisor_top
// Multi-client software watchdog: per-slot countdowns with sticky trip.
// ----------------------------------------------------------------------------
module multi_client_watchdog_supervisor_top #(
    parameter int NUM_FEEDERS = mcws_pkg::NUM_FEEDERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mcws_pkg::t_in_item             i_in_item,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mcws_pkg::t_out_item            o_out_item,
    // Configuration channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mcws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mcws_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import mcws_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cfg_we;

    // Configuration beats are always taken.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Command sequencer.
    mcws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Slot storage and arithmetic.
    mcws_dp #(
        .NUM_FEEDERS (NUM_FEEDERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule

// File: rtl/core/mcws_ctrl.sv
// ----------------------------------------------------------------------------
// mcws_ctrl
// Sequencer that steps the datapath through each command and the slot walk.
// ----------------------------------------------------------------------------
module mcws_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mcws_pkg::t_dp_status i_status,
    output mcws_pkg::t_dp_cmd   o_cmd
);
    import mcws_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_status.op)
                    OP_PROMISE, OP_REMOVE: n_state = ST_RESP;
                    OP_SIGNAL:             n_state = ST_SIG_WR;
                    OP_TICK:               n_state = i_status.running ? ST_WALK : ST_RESP;
                    default:               n_state = ST_RESP;
                endcase
            end
            ST_SIG_WR: begin
                n_state = ST_RESP;
            end
            ST_WALK: begin
                if (i_status.walk_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.promise_wr = (i_status.op == OP_PROMISE);
                o_cmd.remove_wr  = (i_status.op == OP_REMOVE);
                o_cmd.sig_rd     = (i_status.op == OP_SIGNAL);
                o_cmd.walk_start = (i_status.op == OP_TICK) && i_status.running;
            end
            ST_SIG_WR: begin
                o_cmd.sig_wr = 1'b1;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
            end
            ST_RESP: begin
                o_cmd.resp_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/mcws_dp.sv
// ----------------------------------------------------------------------------
// mcws_dp
// Slot storage, countdown arithmetic, configuration and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcws_dp #(
    parameter int NUM_FEEDERS = mcws_pkg::NUM_FEEDERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [mcws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mcws_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // Input payload.
    input  mcws_pkg::t_in_item                i_in_item,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mcws_pkg::t_out_item               o_out_item,
    // Controller link.
    input  mcws_pkg::t_dp_cmd                 i_cmd,
    output mcws_pkg::t_dp_status              o_status
);
    import mcws_pkg::*;

    localparam int IDX_W = (NUM_FEEDERS > 1) ? $clog2(NUM_FEEDERS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FEEDERS - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_FEEDERS);

    // Configuration registers.
    logic [REV_W-1:0]  r_hw_rev;
    logic              r_hw_wdog;
    logic [TICK_W-1:0] r_tick_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw_rev  <= HW_REV_RST;
            r_hw_wdog <= HW_WDOG_RST;
            r_tick_ms <= TICK_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HW_REV:  r_hw_rev  <= i_cfg_data[REV_W-1:0];
                CFG_HW_WDOG: r_hw_wdog <= i_cfg_data[0];
                CFG_TICK_MS: r_tick_ms <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured input item.
    t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    logic             slot_in_range;
    logic [IDX_W-1:0] slot_addr;

    assign slot_in_range = (32'(r_item.feeder_slot) < 32'(NUM_FEEDERS));
    assign slot_addr     = IDX_W'(r_item.feeder_slot);

    // Slot valid bits.
    logic [NUM_FEEDERS-1:0] r_slot_valid;
    logic                   slot_is_valid;

    assign slot_is_valid = slot_in_range && r_slot_valid[slot_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (slot_in_range) begin
            if (i_cmd.promise_wr) begin
                r_slot_valid[slot_addr] <= 1'b1;
            end else if (i_cmd.remove_wr) begin
                r_slot_valid[slot_addr] <= 1'b0;
            end
        end
    end

    // Promised timeout memory, read when a signal reloads a countdown.
    logic [TMO_W-1:0] mem_pt [NUM_FEEDERS];
    logic [TMO_W-1:0] r_pt_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.promise_wr && slot_in_range) begin
            mem_pt[slot_addr] <= r_item.timeout_ms;
        end
        if (i_cmd.sig_rd && slot_in_range) begin
            r_pt_rd <= mem_pt[slot_addr];
        end
    end

    // Walk counters: r_idx issues reads, r_widx is the slot being written back.
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_widx;
    logic             r_pend;
    logic             rd_issue;

    assign rd_issue = i_cmd.walk_step && (r_idx < CNT_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.walk_start) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_pend <= rd_issue;
            if (rd_issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_widx <= r_idx[IDX_W-1:0];
        end
    end

    // Countdown memory with one write port and one registered read port.
    logic [CD_W-1:0]  mem_cd [NUM_FEEDERS];
    logic [CD_W-1:0]  r_cd_rd;
    logic             cd_we;
    logic [IDX_W-1:0] cd_waddr;
    logic [CD_W-1:0]  cd_wdata;

    always_ff @(posedge i_clk) begin
        if (cd_we) begin
            mem_cd[cd_waddr] <= cd_wdata;
        end
        if (rd_issue) begin
            r_cd_rd <= mem_cd[r_idx[IDX_W-1:0]];
        end
    end

    // Decrement with saturation at the 21-bit minimum.
    logic [CD_W:0]   cd_diff;
    logic            cd_sat;
    logic [CD_W-1:0] cd_next;
    logic            wb_active;
    logic            wb_fail;

    assign cd_diff   = {r_cd_rd[CD_W-1], r_cd_rd} - {{(CD_W+1-TICK_W){1'b0}}, r_tick_ms};
    assign cd_sat    = cd_diff[CD_W] && !cd_diff[CD_W-1];
    assign cd_next   = cd_sat ? CD_MIN : cd_diff[CD_W-1:0];
    assign wb_active = i_cmd.walk_step && r_pend && r_slot_valid[r_widx];
    assign wb_fail   = wb_active && cd_next[CD_W-1];

    // Write port selection.
    logic sig_ok;

    assign sig_ok = (r_hw_rev != HW_REV_NO_SIGNAL) && slot_is_valid;

    always_comb begin
        cd_we    = 1'b0;
        cd_waddr = slot_addr;
        cd_wdata = {1'b0, r_item.timeout_ms};
        if (i_cmd.promise_wr && slot_in_range) begin
            cd_we = 1'b1;
        end else if (i_cmd.sig_wr && sig_ok) begin
            cd_we    = 1'b1;
            cd_wdata = {1'b0, r_pt_rd};
        end else if (wb_active) begin
            cd_we    = 1'b1;
            cd_waddr = r_widx;
            cd_wdata = cd_next;
        end
    end

    // Running flag and failure capture.
    logic             r_running;
    logic             r_fail_valid;
    logic [SLOT_W-1:0] r_failed_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b1;
            r_fail_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_fail_valid <= 1'b0;
        end else if (wb_fail) begin
            r_running    <= 1'b0;
            r_fail_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_failed_slot <= '0;
        end else if (wb_fail && !r_fail_valid) begin
            r_failed_slot <= SLOT_W'(r_widx);
        end
    end

    // Result register, free when empty or being taken this cycle.
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resp_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            r_out.keepalive   <= (r_item.cmd == OP_TICK) && r_running && r_hw_wdog;
            r_out.tripped     <= !r_running;
            r_out.fail_valid  <= r_fail_valid;
            r_out.failed_slot <= r_failed_slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status back to the controller.
    assign o_status.op        = r_item.cmd;
    assign o_status.running   = r_running;
    assign o_status.walk_done = r_pend && (r_widx == LAST_IDX);
    assign o_status.out_free  = out_free;

    // Once tripped, the supervisor stays tripped until reset.
    `MCWS_ASSERT(a_trip_sticky, i_clk, i_rst_n, !r_running |=> !r_running)
    // A reported failure always comes with the tripped flag.
    `MCWS_ASSERT(a_fail_trips, i_clk, i_rst_n, (r_out_valid && r_out.fail_valid) |-> r_out.tripped)
    // No keepalive leaves a tripped supervisor.
    `MCWS_ASSERT(a_keep_untripped, i_clk, i_rst_n,
        (r_out_valid && r_out.keepalive) |-> !r_out.tripped)
    // Reset empties the result register.
    `MCWS_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid)

endmodule
